// File: rtl/core/rba_pkg.sv
// ----------------------------------------------------------------------------
// rba_pkg
// Shared types, codes and helpers for the ring buffer allocator.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int unsigned POS_W      = 17;
  localparam int unsigned SUM_W      = 19;
  localparam int unsigned OFS_W      = 16;
  localparam int unsigned LG_W       = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned ADDR_BITS  = 16;
  localparam logic [POS_W-1:0] CAPACITY_RST = 17'h10000;
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_POP   = 2'd1,
    OP_RESET = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_POP_EMPTY = 2'd2,
    STAT_OVERSHOOT = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clear;
  } cmd_t;

  function automatic logic [SUM_W-1:0] pow2_ceil(input logic [SUM_W-1:0] x,
                                                input logic [LG_W-1:0] lg);
    logic [SUM_W-1:0] m;
    m = (SUM_W'(1) << lg) - SUM_W'(1);
    return (x + m) & ~m;
  endfunction

endpackage

// File: rtl/core/rba_cfg.sv
// ----------------------------------------------------------------------------
// rba_cfg
// APB register slice holding the arena capacity.
// ----------------------------------------------------------------------------
module rba_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rba_pkg::PADDR_W-1:0] paddr,
  input  logic [rba_pkg::DATA_W-1:0]  pwdata,
  output logic [rba_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [rba_pkg::POS_W-1:0]   capacity,
  output logic                        cap_wr
);

  logic sel_cap;

  assign sel_cap = (paddr[2] == rba_pkg::REG_CAPACITY);
  assign cap_wr  = psel && penable && pwrite && sel_cap;
  assign pready  = 1'b1;
  assign prdata  = sel_cap ? rba_pkg::DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rba_pkg::CAPACITY_RST;
    end else if (cap_wr) begin
      capacity <= pwdata[rba_pkg::POS_W-1:0];
    end
  end

endmodule

// File: rtl/core/rba_ctrl.sv
// ----------------------------------------------------------------------------
// rba_ctrl
// Request sequencer: latches a request, then runs a single execute state.
// ----------------------------------------------------------------------------
module rba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          cap_wr,
  output logic          busy,
  output rba_pkg::cmd_t cmd
);

  rba_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.clear  = cap_wr;
    busy       = (state == rba_pkg::S_EXEC);
    unique case (state)
      rba_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = rba_pkg::S_EXEC;
        end
      end
      rba_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = rba_pkg::S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");
  a_exec_single: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy) else $error("execute phase longer than one cycle");

endmodule

// File: rtl/core/rba_dp.sv
// ----------------------------------------------------------------------------
// rba_dp
// Pointer datapath: operand latch, head/tail/wrap state and result register.
// ----------------------------------------------------------------------------
module rba_dp #(
  parameter int unsigned ADDR_BITS = rba_pkg::ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rba_pkg::cmd_t              cmd,
  input  logic [rba_pkg::POS_W-1:0]  capacity,
  input  logic [1:0]                 operation,
  input  logic [rba_pkg::POS_W-1:0]  block_size,
  input  logic [rba_pkg::LG_W-1:0]   align_log2,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [rba_pkg::OFS_W-1:0]  offset,
  output logic                       is_empty
);

  localparam int unsigned POS_W  = rba_pkg::POS_W;
  localparam int unsigned SUM_W  = rba_pkg::SUM_W;
  localparam int unsigned LIM_SH = (ADDR_BITS > POS_W) ? POS_W : ADDR_BITS;
  localparam logic [POS_W:0] LIM = (POS_W+1)'(1) << LIM_SH;
  localparam logic [POS_W-1:0] WRAP_RST = ({1'b0, rba_pkg::CAPACITY_RST} > LIM) ?
                                          LIM[POS_W-1:0] : rba_pkg::CAPACITY_RST;

  logic [1:0]                op_q;
  logic [POS_W-1:0]          size_q;
  logic [rba_pkg::LG_W-1:0]  lg_q;

  logic [POS_W-1:0] head_pos, tail_pos, wrap_end;
  logic             empty_flag;
  logic [POS_W-1:0] head_next, tail_next, wrap_next;
  logic             empty_next;

  logic [POS_W-1:0]         cap;
  logic [SUM_W-1:0]         cap19, size19, head19, tail19, wrap19;
  logic [SUM_W-1:0]         a_offs, a_end, p_t, p_end, offs, t;
  logic [POS_W-1:0]         new_end;
  logic                     ok;
  rba_pkg::status_t         st;
  logic [rba_pkg::OFS_W-1:0] offs_res;

  assign cap    = ({1'b0, capacity} > LIM) ? LIM[POS_W-1:0] : capacity;
  assign cap19  = SUM_W'(cap);
  assign size19 = SUM_W'(size_q);
  assign head19 = SUM_W'(head_pos);
  assign tail19 = SUM_W'(tail_pos);
  assign wrap19 = SUM_W'(wrap_end);
  assign a_offs = rba_pkg::pow2_ceil(head19, lg_q);
  assign a_end  = a_offs + size19;
  assign p_t    = rba_pkg::pow2_ceil(tail19, lg_q);
  assign p_end  = p_t + size19;

  always_comb begin
    head_next  = head_pos;
    tail_next  = tail_pos;
    wrap_next  = wrap_end;
    empty_next = empty_flag;
    st         = rba_pkg::STAT_OK;
    offs_res   = '0;
    offs       = a_offs;
    t          = p_end;
    ok         = 1'b1;
    new_end    = wrap_end;
    unique case (rba_pkg::op_t'(op_q))
      rba_pkg::OP_ALLOC: begin
        if (empty_flag) begin
          if (a_end >= cap19) begin
            offs = '0;
            if (size19 >= cap19) ok = 1'b0;
          end
          if (ok) begin
            tail_next  = offs[POS_W-1:0];
            wrap_next  = cap;
            empty_next = 1'b0;
          end
        end else begin
          if (head19 <= tail19 && a_end > tail19) ok = 1'b0;
          if (ok && a_end >= cap19) begin
            if (tail_pos == '0 || size19 > tail19) begin
              ok = 1'b0;
            end else begin
              new_end = head_pos;
              offs    = '0;
            end
          end
          if (ok) wrap_next = new_end;
        end
        if (ok) begin
          head_next = POS_W'(offs + size19);
          offs_res  = offs[rba_pkg::OFS_W-1:0];
        end else begin
          st = rba_pkg::STAT_NO_SPACE;
        end
      end
      rba_pkg::OP_POP: begin
        if (empty_flag) begin
          st = rba_pkg::STAT_POP_EMPTY;
        end else if (p_end > wrap19) begin
          empty_next = 1'b1;
          st         = rba_pkg::STAT_OVERSHOOT;
        end else begin
          if (p_end == wrap19) begin
            wrap_next = cap;
            t         = '0;
          end
          if (t == head19) empty_next = 1'b1;
          else tail_next = t[POS_W-1:0];
        end
      end
      rba_pkg::OP_RESET: begin
        head_next  = '0;
        tail_next  = '0;
        wrap_next  = cap;
        empty_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      size_q <= block_size;
      lg_q   <= align_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_pos   <= '0;
      tail_pos   <= '0;
      wrap_end   <= WRAP_RST;
      empty_flag <= 1'b1;
    end else if (cmd.clear) begin
      head_pos   <= '0;
      tail_pos   <= '0;
      empty_flag <= 1'b1;
    end else if (cmd.exec) begin
      head_pos   <= head_next;
      tail_pos   <= tail_next;
      wrap_end   <= wrap_next;
      empty_flag <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status   <= st;
      offset   <= offs_res;
      is_empty <= empty_next;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done) else $error("execute without result strobe");
  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    (done && status != rba_pkg::STAT_OK) |-> (offset == '0))
    else $error("nonzero offset on failed request");
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> empty_flag) else $error("capacity write left ring non-empty");

endmodule

// File: rtl/core/ring_buffer_allocator.sv
// ----------------------------------------------------------------------------
// ring_buffer_allocator
// Circular byte arena allocator: alloc, pop-oldest and ring reset requests.
// The accepting edge latches the operands and enters EXEC; done is registered from EXEC.
// A new request is accepted only in IDLE, not while busy, as the latch/execute sequencer sets.
// busy is high for the single execute cycle; the return to IDLE frees it.
// done is a one-cycle strobe; the receiver cannot stall.
// Reset: ring empty, head at 0, capacity 65536; no clearing pass.
// ----------------------------------------------------------------------------
module ring_buffer_allocator #(
  parameter int unsigned ADDR_BITS = rba_pkg::ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation,
  input  logic [rba_pkg::POS_W-1:0]   block_size,
  input  logic [rba_pkg::LG_W-1:0]    align_log2,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [rba_pkg::OFS_W-1:0]   offset,
  output logic                        is_empty,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rba_pkg::PADDR_W-1:0] paddr,
  input  logic [rba_pkg::DATA_W-1:0]  pwdata,
  output logic [rba_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  rba_pkg::cmd_t                cmd;
  logic [rba_pkg::POS_W-1:0]    capacity;
  logic                         cap_wr;

  rba_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity),
    .cap_wr   (cap_wr)
  );

  rba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cap_wr (cap_wr),
    .busy   (busy),
    .cmd    (cmd)
  );

  rba_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .capacity   (capacity),
    .operation  (operation),
    .block_size (block_size),
    .align_log2 (align_log2),
    .done       (done),
    .status     (status),
    .offset     (offset),
    .is_empty   (is_empty)
  );

endmodule
